// File: hw/rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // discriminant magnitude b*b + 4|ac| needs one bit over a double word
    localparam int D_BITS    = 2 * WORD_BITS + 1;
    localparam int ROOT_BITS = WORD_BITS + 1;
    // numerator magnitude |-b +/- s| and its sign-extended form
    localparam int NUM_BITS  = WORD_BITS + 2;
    localparam int NUMS_BITS = WORD_BITS + 3;
    localparam int QUO_BITS  = NUM_BITS + FRAC_BITS;
    localparam int DEN_BITS  = WORD_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] coef_a;
        logic signed [WORD_BITS-1:0] coef_b;
        logic signed [WORD_BITS-1:0] coef_c;
    } in_t;

    typedef struct packed {
        logic [1:0]                  root_kind;
        logic signed [WORD_BITS-1:0] first_value;
        logic signed [WORD_BITS-1:0] second_value;
        logic                        saturated;
    } out_t;

    // fields that ride along the square root pipeline
    typedef struct packed {
        kind_t                     kind;
        logic                      a_neg;
        logic [WORD_BITS-1:0]      a_mag;
        logic signed [WORD_BITS:0] neg_b;
    } side_t;

    // one classified equation waiting in the queue
    typedef struct packed {
        side_t             side;
        logic [D_BITS-1:0] d_mag;
    } work_t;

    // fields that ride along the divider pipeline
    typedef struct packed {
        kind_t kind;
        logic  diff1;
        logic  diff2;
    } dside_t;

endpackage

// File: hw/rtl/qrs_front.sv
// Front end: accept coefficients, form the discriminant and classify the roots.
module qrs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  qrs_pkg::in_t    s_data,
    output logic            push_valid,
    input  logic            push_space,
    output qrs_pkg::work_t  push_data
);
    localparam int W = qrs_pkg::WORD_BITS;
    localparam int D = qrs_pkg::D_BITS;

    logic               v1_reg, v2_reg, v3_reg;
    logic               an1_reg, cn1_reg, bn1_reg;
    logic [W-1:0]       am1_reg, bm1_reg, cm1_reg;
    logic               an2_reg, cn2_reg, bn2_reg;
    logic [W-1:0]       am2_reg, bm2_reg;
    logic [2*W-1:0]     b2_reg, ac_reg;
    qrs_pkg::work_t     w3_reg, w3_next;
    logic               adv;
    logic [D:0]         b2e, ac4, dsum, ddiff, drev;

    // the whole front moves when the queue has room
    assign adv        = push_space;
    assign s_ready    = adv;
    assign push_valid = v3_reg;
    assign push_data  = w3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // split into sign and magnitude
    always_ff @(posedge aclk) begin
        if (adv) begin
            an1_reg <= s_data.coef_a[W-1];
            bn1_reg <= s_data.coef_b[W-1];
            cn1_reg <= s_data.coef_c[W-1];
            am1_reg <= s_data.coef_a[W-1] ? -s_data.coef_a : s_data.coef_a;
            bm1_reg <= s_data.coef_b[W-1] ? -s_data.coef_b : s_data.coef_b;
            cm1_reg <= s_data.coef_c[W-1] ? -s_data.coef_c : s_data.coef_c;
        end
    end

    // form the two products
    always_ff @(posedge aclk) begin
        if (adv) begin
            an2_reg <= an1_reg;
            bn2_reg <= bn1_reg;
            cn2_reg <= cn1_reg;
            am2_reg <= am1_reg;
            bm2_reg <= bm1_reg;
            b2_reg  <= bm1_reg * bm1_reg;
            ac_reg  <= am1_reg * cm1_reg;
        end
    end

    // combine into the discriminant and classify
    always_comb begin
        b2e   = {2'b00, b2_reg};
        ac4   = {ac_reg, 2'b00};
        dsum  = b2e + ac4;
        ddiff = b2e - ac4;
        drev  = ac4 - b2e;
        w3_next.side.a_neg = an2_reg;
        w3_next.side.a_mag = am2_reg;
        w3_next.side.neg_b = bn2_reg ? {1'b0, bm2_reg} : -{1'b0, bm2_reg};
        if (an2_reg != cn2_reg) begin
            w3_next.d_mag     = dsum[D-1:0];
            w3_next.side.kind = qrs_pkg::KIND_TWO_REAL;
        end else if (b2e >= ac4) begin
            w3_next.d_mag     = ddiff[D-1:0];
            w3_next.side.kind = qrs_pkg::KIND_TWO_REAL;
        end else begin
            w3_next.d_mag     = drev[D-1:0];
            w3_next.side.kind = qrs_pkg::KIND_COMPLEX;
        end
        if (w3_next.side.kind == qrs_pkg::KIND_TWO_REAL && w3_next.d_mag == '0) begin
            w3_next.side.kind = qrs_pkg::KIND_DOUBLE;
        end
        if (am2_reg == '0) begin
            w3_next.side.kind = qrs_pkg::KIND_A_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w3_reg <= w3_next;
        end
    end

endmodule

// File: hw/rtl/qrs_queue.sv
// Short queue of classified items between the front and back ends.
module qrs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_space,
    input  qrs_pkg::work_t  push_data,
    input  logic            pop_req,
    output logic            pop_valid,
    output qrs_pkg::work_t  pop_data
);
    localparam int DEPTH = qrs_pkg::QUEUE_DEPTH;
    localparam int PB    = qrs_pkg::QPTR_BITS;

    qrs_pkg::work_t  slot_reg [DEPTH];
    logic [PB-1:0]   wr_reg, rd_reg;
    logic [PB:0]     count_reg;
    logic            do_push, do_pop;

    assign push_space = (count_reg != DEPTH[PB:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_space;
    assign do_pop     = pop_req && pop_valid;

    // advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + {{PB{1'b0}}, do_push} - {{PB{1'b0}}, do_pop};
        end
    end

    // store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/qrs_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module qrs_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [qrs_pkg::D_BITS-1:0]    radicand,
    input  qrs_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [qrs_pkg::ROOT_BITS-1:0] root,
    output qrs_pkg::side_t                out_side
);
    localparam int R  = qrs_pkg::ROOT_BITS;
    localparam int RW = R + 2;
    localparam int NB = 2 * R;

    logic           v_reg    [R];
    logic [NB-1:0]  rad_reg  [R];
    logic [RW-1:0]  rem_reg  [R];
    logic [R-1:0]   root_reg [R];
    qrs_pkg::side_t side_reg [R];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < R; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < R; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic [NB-1:0]  p_rad;
        logic [RW-1:0]  p_rem, sh, trial;
        logic [R-1:0]   p_root;
        qrs_pkg::side_t p_side;
        if (k == 0) begin : g_first
            assign p_rad  = {{(NB - qrs_pkg::D_BITS){1'b0}}, radicand};
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = in_side;
        end else begin : g_next
            assign p_rad  = rad_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_side = side_reg[k-1];
        end
        assign sh    = {p_rem[RW-3:0], p_rad[NB-1:NB-2]};
        assign trial = {p_root, 2'b01};

        // try the next root bit and keep it when the remainder allows
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {p_rad[NB-3:0], 2'b00};
                side_reg[k] <= p_side;
                if (sh >= trial) begin
                    rem_reg[k]  <= sh - trial;
                    root_reg[k] <= {p_root[R-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= sh;
                    root_reg[k] <= {p_root[R-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[R-1];
    assign root      = root_reg[R-1];
    assign out_side  = side_reg[R-1];

endmodule

// File: hw/rtl/qrs_div.sv
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage.
module qrs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [qrs_pkg::QUO_BITS-1:0] num1,
    input  logic [qrs_pkg::QUO_BITS-1:0] num2,
    input  logic [qrs_pkg::DEN_BITS-1:0] den,
    input  qrs_pkg::dside_t              in_side,
    output logic                         out_valid,
    output logic [qrs_pkg::QUO_BITS-1:0] quo1,
    output logic [qrs_pkg::QUO_BITS-1:0] quo2,
    output qrs_pkg::dside_t              out_side
);
    localparam int Q  = qrs_pkg::QUO_BITS;
    localparam int DB = qrs_pkg::DEN_BITS;

    logic            v_reg    [Q];
    logic [Q-1:0]    n1_reg   [Q];
    logic [Q-1:0]    n2_reg   [Q];
    logic [DB-1:0]   r1_reg   [Q];
    logic [DB-1:0]   r2_reg   [Q];
    logic [Q-1:0]    q1_reg   [Q];
    logic [Q-1:0]    q2_reg   [Q];
    logic [DB-1:0]   den_reg  [Q];
    qrs_pkg::dside_t side_reg [Q];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Q; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < Q; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [Q-1:0]    p_n1, p_n2, p_q1, p_q2;
        logic [DB-1:0]   p_r1, p_r2, p_den;
        logic [DB:0]     sh1, sh2, dx;
        qrs_pkg::dside_t p_side;
        if (k == 0) begin : g_first
            assign p_n1   = num1;
            assign p_n2   = num2;
            assign p_r1   = '0;
            assign p_r2   = '0;
            assign p_q1   = '0;
            assign p_q2   = '0;
            assign p_den  = den;
            assign p_side = in_side;
        end else begin : g_next
            assign p_n1   = n1_reg[k-1];
            assign p_n2   = n2_reg[k-1];
            assign p_r1   = r1_reg[k-1];
            assign p_r2   = r2_reg[k-1];
            assign p_q1   = q1_reg[k-1];
            assign p_q2   = q2_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_side = side_reg[k-1];
        end
        assign sh1 = {p_r1, p_n1[Q-1]};
        assign sh2 = {p_r2, p_n2[Q-1]};
        assign dx  = {1'b0, p_den};

        // bring down a numerator bit and subtract where it fits
        always_ff @(posedge aclk) begin
            if (en) begin
                n1_reg[k]   <= {p_n1[Q-2:0], 1'b0};
                n2_reg[k]   <= {p_n2[Q-2:0], 1'b0};
                den_reg[k]  <= p_den;
                side_reg[k] <= p_side;
                q1_reg[k]   <= {p_q1[Q-2:0], sh1 >= dx};
                q2_reg[k]   <= {p_q2[Q-2:0], sh2 >= dx};
                r1_reg[k]   <= (sh1 >= dx) ? DB'(sh1 - dx) : sh1[DB-1:0];
                r2_reg[k]   <= (sh2 >= dx) ? DB'(sh2 - dx) : sh2[DB-1:0];
            end
        end
    end

    assign out_valid = v_reg[Q-1];
    assign quo1      = q1_reg[Q-1];
    assign quo2      = q2_reg[Q-1];
    assign out_side  = side_reg[Q-1];

endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Top level: front end, queue, square root and divider back end, output register.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   qrs_pkg::in_t  coefficients a, b, c
//   m_       out        m_valid / m_ready   qrs_pkg::out_t kind, two values, flag
//
// One item per cycle sustained while m_ready stays high. An item passes 3 + 1 + 33 + 1 + 50 + 1
// = 89 registers on its way to m_valid. The one-bit-per-stage square root and divider
// pipelines set this count.
// aresetn is synchronous and clears only the valid bits and the queue pointers and count.
// The back end stalls as a whole while a result waits; the four-entry queue
// lets the front end keep accepting until it fills.
module quadratic_root_solver (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qrs_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output qrs_pkg::out_t  m_data
);
    localparam int W  = qrs_pkg::WORD_BITS;
    localparam int F  = qrs_pkg::FRAC_BITS;
    localparam int R  = qrs_pkg::ROOT_BITS;
    localparam int NS = qrs_pkg::NUMS_BITS;
    localparam int NM = qrs_pkg::NUM_BITS;
    localparam int Q  = qrs_pkg::QUO_BITS;
    localparam logic [Q-1:0] HALF = {{(Q - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};

    logic            push_valid, push_space, pop_valid, back_adv;
    qrs_pkg::work_t  push_data, pop_data;
    logic            sq_valid, dv_valid;
    logic [R-1:0]    sq_root;
    qrs_pkg::side_t  sq_side;
    qrs_pkg::dside_t dv_side, n_side_reg;
    logic            n_valid_reg;
    logic [Q-1:0]    n1_reg, n2_reg, quo1, quo2;
    logic [qrs_pkg::DEN_BITS-1:0] den_reg;
    logic [NS-1:0]   nb_e, s_e, v1, v2;
    logic [NM-1:0]   m1, m2;
    logic            out_valid_reg;
    qrs_pkg::out_t   out_reg, out_next;
    logic            neg1, neg2, sat1, sat2;
    logic [Q-1:0]    lim1, lim2, c1, c2;

    qrs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_space (push_space),
        .push_data  (push_data)
    );

    qrs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_space (push_space),
        .push_data  (push_data),
        .pop_req    (back_adv),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    // the back end advances whenever the output register is free or being taken
    assign back_adv = !out_valid_reg || m_ready;

    qrs_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_adv),
        .in_valid  (pop_valid),
        .radicand  (pop_data.d_mag),
        .in_side   (pop_data.side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // form both numerators as sign and magnitude
    always_comb begin
        nb_e = {{(NS - W - 1){sq_side.neg_b[W]}}, sq_side.neg_b};
        s_e  = {{(NS - R){1'b0}}, sq_root};
        if (sq_side.kind == qrs_pkg::KIND_COMPLEX) begin
            v1 = nb_e;
            v2 = s_e;
        end else begin
            v1 = nb_e + s_e;
            v2 = nb_e - s_e;
        end
        m1 = v1[NS-1] ? NM'(-v1) : v1[NM-1:0];
        m2 = v2[NS-1] ? NM'(-v2) : v2[NM-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (back_adv) begin
            n_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_adv) begin
            n1_reg           <= {m1, {F{1'b0}}};
            n2_reg           <= {m2, {F{1'b0}}};
            den_reg          <= {sq_side.a_mag, 1'b0};
            n_side_reg.kind  <= sq_side.kind;
            n_side_reg.diff1 <= v1[NS-1] != sq_side.a_neg;
            n_side_reg.diff2 <= v2[NS-1] != sq_side.a_neg;
        end
    end

    qrs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_adv),
        .in_valid  (n_valid_reg),
        .num1      (n1_reg),
        .num2      (n2_reg),
        .den       (den_reg),
        .in_side   (n_side_reg),
        .out_valid (dv_valid),
        .quo1      (quo1),
        .quo2      (quo2),
        .out_side  (dv_side)
    );

    // clamp, restore sign and flag saturation; a zero a gives zero values and no flag
    always_comb begin
        neg1 = dv_side.diff1 && (quo1 != '0);
        neg2 = dv_side.diff2 && (quo2 != '0);
        lim1 = neg1 ? HALF : HALF - 1'b1;
        lim2 = neg2 ? HALF : HALF - 1'b1;
        sat1 = quo1 > lim1;
        sat2 = quo2 > lim2;
        c1   = sat1 ? lim1 : quo1;
        c2   = sat2 ? lim2 : quo2;
        out_next.root_kind    = dv_side.kind;
        out_next.first_value  = neg1 ? -c1[W-1:0] : c1[W-1:0];
        out_next.second_value = neg2 ? -c2[W-1:0] : c2[W-1:0];
        out_next.saturated    = sat1 || sat2;
        if (dv_side.kind == qrs_pkg::KIND_A_ZERO) begin
            out_next.first_value  = '0;
            out_next.second_value = '0;
            out_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (back_adv) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
